// ----- hw/rtl/crrs_pkg.sv -----
// Package for circle_ring_row_spans: widths, payload structs between pipeline
// segments, coordinate saturation and the one-digit square root step.
// No dependencies.
package crrs_pkg;

    // Radius width in bits; radius and thickness use their low RADIUS_BITS bits
    localparam int RADIUS_BITS = 11;
    localparam int RB          = RADIUS_BITS;

    // Fixed field widths
    localparam int COORD_W  = 20;
    localparam int DIM_W    = 11;
    localparam int DY_W     = 12;
    localparam int COLOR_W  = 32;
    localparam int CFG_W    = 20;
    localparam int IN_W     = 112;
    localparam int OUT_W    = 136;

    // Derived widths: compare width, radicand, root accumulator, span sum
    localparam int CMP_W = (RB > DY_W) ? RB : DY_W;
    localparam int NW    = 2 * RB;
    localparam int RW    = 2 * RB + 1;
    localparam int SW    = 22;

    localparam int COORD_MAX = 524287;
    localparam int COORD_MIN = -524288;

    // Configuration register indexes
    localparam logic [0:0] REG_CAMERA_X = 1'b0;
    localparam logic [0:0] REG_CAMERA_Y = 1'b1;

    // Span counts
    localparam logic [1:0] SPANS_NONE = 2'd0;
    localparam logic [1:0] SPANS_ONE  = 2'd1;
    localparam logic [1:0] SPANS_TWO  = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Fields that ride alongside the square roots
    typedef struct packed {
        t_coord               cx;
        t_coord               row_y;
        logic                 dz;
        logic [1:0]           count;
        logic [COLOR_W-1:0]   color;
    } t_side;

    // Front segment result: radicands for outer and inner circle
    typedef struct packed {
        t_side           side;
        logic [NW-1:0]   n_out;
        logic [NW-1:0]   n_in;
    } t_rad;

    // One square root lane in flight
    typedef struct packed {
        logic [NW-1:0] rem;
        logic [RW-1:0] root;
    } t_lane;

    // Root segment result: raw half-widths in pixels
    typedef struct packed {
        t_side           side;
        logic [RB-1:0]   d_out;
        logic [RB-1:0]   d_in;
    } t_half;

    // Clamp to the Q16.4 coordinate range
    function automatic t_coord sat20(input logic signed [SW-1:0] v);
        t_coord res;
        if (v > $signed(SW'(COORD_MAX))) begin
            res = t_coord'(COORD_MAX);
        end else if (v < $signed(SW'(COORD_MIN))) begin
            res = t_coord'(COORD_MIN);
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // One digit of the restoring square root, trial bit at 2^sh
    function automatic t_lane sqrt_step(input t_lane a, input int sh);
        t_lane         res;
        logic [RW-1:0] bitv;
        logic [RW:0]   need;
        bitv = RW'(1) << sh;
        need = {1'b0, a.root} + {1'b0, bitv};
        if ({{(RW + 1 - NW){1'b0}}, a.rem} >= need) begin
            res.rem  = a.rem - need[NW-1:0];
            res.root = (a.root >> 1) + bitv;
        end else begin
            res.rem  = a.rem;
            res.root = a.root >> 1;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/crrs_front.sv -----
// Front segment: camera offset, row classification, squares and radicands.
// Four register stages. Depends on crrs_pkg.
module crrs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crrs_pkg::t_coord              i_cam_x,
    input  crrs_pkg::t_coord              i_cam_y,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  crrs_pkg::t_coord              i_center_x,
    input  crrs_pkg::t_coord              i_center_y,
    input  logic [crrs_pkg::DIM_W-1:0]    i_radius,
    input  logic [crrs_pkg::DIM_W-1:0]    i_thickness,
    input  logic signed [crrs_pkg::DY_W-1:0] i_row_offset,
    input  logic [crrs_pkg::COLOR_W-1:0]  i_color,
    output logic                          o_valid,
    input  logic                          i_ready,
    output crrs_pkg::t_rad                o_rad
);
    import crrs_pkg::*;

    logic [3:0] r_v;
    logic [3:0] en;

    // Stage A registers
    t_coord                  r_a_cx, r_a_cy;
    logic [RB-1:0]           r_a_r, r_a_t;
    logic signed [DY_W-1:0]  r_a_dy;
    logic [COLOR_W-1:0]      r_a_color;

    // Stage B registers
    t_side                   r_b_side;
    logic [RB-1:0]           r_b_r, r_b_ir, r_b_ady;

    // Stage C registers
    t_side                   r_c_side;
    logic [NW-1:0]           r_c_rr, r_c_ii, r_c_dd;

    // Stage D register
    t_rad                    r_d;

    // Stage A logic
    logic signed [SW-1:0]    n_cx_w, n_cy_w;
    // Stage B logic
    logic [DY_W-1:0]         ady;
    logic [RB-1:0]           ir;
    logic                    span, ring;
    t_side                   n_b_side;

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        en[3] = !r_v[3] || i_ready;
        en[2] = !r_v[2] || en[3];
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
    end
    assign o_ready = en[0];
    assign o_valid = r_v[3];
    assign o_rad   = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    // Stage A: subtract camera offset with saturation
    assign n_cx_w = SW'(i_center_x) - SW'(i_cam_x);
    assign n_cy_w = SW'(i_center_y) - SW'(i_cam_y);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_cx    <= sat20(n_cx_w);
            r_a_cy    <= sat20(n_cy_w);
            r_a_r     <= RB'(i_radius);
            r_a_t     <= RB'(i_thickness);
            r_a_dy    <= i_row_offset;
            r_a_color <= i_color;
        end
    end

    // Stage B: classify the row as empty, filled or ring, and place row_y
    always_comb begin
        ady  = r_a_dy[DY_W-1] ? DY_W'(-r_a_dy) : DY_W'(r_a_dy);
        ir   = r_a_r - r_a_t;
        span = (r_a_r != '0) && (CMP_W'(ady) < CMP_W'(r_a_r));
        ring = span && (r_a_t != '0) && (r_a_t < r_a_r) && (CMP_W'(ady) < CMP_W'(ir));
        n_b_side.cx    = r_a_cx;
        n_b_side.row_y = sat20(SW'(r_a_cy) + (SW'(r_a_dy) <<< 4));
        n_b_side.dz    = (r_a_dy == '0);
        n_b_side.count = ring ? SPANS_TWO : (span ? SPANS_ONE : SPANS_NONE);
        n_b_side.color = r_a_color;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_side <= n_b_side;
            r_b_r    <= r_a_r;
            r_b_ir   <= ring ? ir : '0;
            r_b_ady  <= span ? RB'(ady) : '0;
        end
    end

    // Stage C: square radius, inner radius and row offset
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c_side <= r_b_side;
            r_c_rr   <= NW'(r_b_r) * NW'(r_b_r);
            r_c_ii   <= NW'(r_b_ir) * NW'(r_b_ir);
            r_c_dd   <= NW'(r_b_ady) * NW'(r_b_ady);
        end
    end

    // Stage D: form radicands r^2 - dy^2
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_d.side  <= r_c_side;
            r_d.n_out <= (r_c_side.count != SPANS_NONE) ? r_c_rr - r_c_dd : '0;
            r_d.n_in  <= (r_c_side.count == SPANS_TWO) ? r_c_ii - r_c_dd : '0;
        end
    end

endmodule

// ----- hw/rtl/crrs_root.sv -----
// Root segment: two integer square roots, one result bit per register stage.
// RADIUS_BITS stages. Depends on crrs_pkg.
module crrs_root (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  crrs_pkg::t_rad  i_rad,
    output logic            o_valid,
    input  logic            i_ready,
    output crrs_pkg::t_half o_half
);
    import crrs_pkg::*;

    logic [RB-1:0]  r_v;
    logic [RB-1:0]  en;
    t_side          r_side [RB];
    t_lane          r_lo   [RB];
    t_lane          r_li   [RB];

    // Ready chain from the last stage back to the first
    always_comb begin
        en[RB-1] = !r_v[RB-1] || i_ready;
        for (int k = RB - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_ready = en[0];
    assign o_valid = r_v[RB-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < RB; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // One digit per stage, most significant first
    for (genvar g = 0; g < RB; g++) begin : g_stage
        localparam int SH = 2 * (RB - 1 - g);
        t_lane lo_in, li_in;
        t_side side_in;
        if (g == 0) begin : g_first
            always_comb begin
                lo_in.rem  = i_rad.n_out;
                lo_in.root = '0;
                li_in.rem  = i_rad.n_in;
                li_in.root = '0;
                side_in    = i_rad.side;
            end
        end else begin : g_next
            always_comb begin
                lo_in   = r_lo[g-1];
                li_in   = r_li[g-1];
                side_in = r_side[g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[g]) begin
                r_side[g] <= side_in;
                r_lo[g]   <= sqrt_step(lo_in, SH);
                r_li[g]   <= sqrt_step(li_in, SH);
            end
        end
    end

    assign o_half.side  = r_side[RB-1];
    assign o_half.d_out = r_lo[RB-1].root[RB-1:0];
    assign o_half.d_in  = r_li[RB-1].root[RB-1:0];

endmodule

// ----- hw/rtl/crrs_spans.sv -----
// Span segment: centre-row trim, pixel to Q16.4 scaling, span ends with
// saturation, held in the output register. Depends on crrs_pkg.
module crrs_spans (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  crrs_pkg::t_half               i_half,
    output logic                          o_valid,
    input  logic                          i_ready,
    output crrs_pkg::t_coord              o_row_y,
    output logic [1:0]                    o_span_count,
    output crrs_pkg::t_coord              o_first_start,
    output crrs_pkg::t_coord              o_first_end,
    output crrs_pkg::t_coord              o_second_start,
    output crrs_pkg::t_coord              o_second_end,
    output logic [crrs_pkg::COLOR_W-1:0]  o_color_out
);
    import crrs_pkg::*;

    logic                 r_valid;
    t_coord               r_row_y, r_fs, r_fe, r_ss, r_se;
    logic [1:0]           r_count;
    logic [COLOR_W-1:0]   r_color;

    logic                 en;
    logic [RB-1:0]        d_o, d_i;
    logic signed [SW-1:0] outer, inner, cxw;
    t_coord               n_fs, n_fe, n_ss, n_se;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    // Trim the centre row, scale to Q16.4 and place the span ends
    always_comb begin
        d_o   = (i_half.side.dz && i_half.d_out != '0) ? i_half.d_out - 1'b1 : i_half.d_out;
        d_i   = (i_half.side.dz && i_half.d_in != '0) ? i_half.d_in - 1'b1 : i_half.d_in;
        outer = $signed(SW'({d_o, 4'b0000}));
        inner = $signed(SW'({d_i, 4'b0000}));
        cxw   = SW'(i_half.side.cx);
        n_fs  = '0;
        n_fe  = '0;
        n_ss  = '0;
        n_se  = '0;
        case (i_half.side.count)
            SPANS_ONE: begin
                n_fs = sat20(cxw - outer);
                n_fe = sat20(cxw + outer);
            end
            SPANS_TWO: begin
                n_fs = sat20(cxw - outer);
                n_fe = sat20(cxw - inner);
                n_ss = sat20(cxw + inner);
                n_se = sat20(cxw + outer);
            end
            default: begin
                n_fs = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_row_y <= i_half.side.row_y;
            r_count <= i_half.side.count;
            r_fs    <= n_fs;
            r_fe    <= n_fe;
            r_ss    <= n_ss;
            r_se    <= n_se;
            r_color <= i_half.side.color;
        end
    end

    assign o_valid        = r_valid;
    assign o_row_y        = r_row_y;
    assign o_span_count   = r_count;
    assign o_first_start  = r_fs;
    assign o_first_end    = r_fe;
    assign o_second_start = r_ss;
    assign o_second_end   = r_se;
    assign o_color_out    = r_color;

endmodule

// ----- hw/rtl/circle_ring_row_spans.sv -----
// Pipeline: four front stages, one square root stage per radius bit, one output
// register. Throughput: one item per cycle while m_axis_tready is high;
// each root stage resolves one bit of both the outer and the inner half-width.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears both camera
// offsets to zero.
module circle_ring_row_spans (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [crrs_pkg::CFG_W-1:0] i_cfg_data,
    // Input items
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: center_x[19:0], center_y[39:20], radius[50:40], thickness[61:51],
    //        row_offset[73:62], color_rgba[105:74], zero[111:106]
    input  logic [crrs_pkg::IN_W-1:0]  s_axis_tdata,
    // Result items
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata: row_y[19:0], span_count[21:20], first_start[41:22], first_end[61:42],
    //        second_start[81:62], second_end[101:82], color_out[133:102], zero[135:134]
    output logic [crrs_pkg::OUT_W-1:0] m_axis_tdata
);
    import crrs_pkg::*;

    t_coord  r_cam_x, r_cam_y;

    logic    f_valid, f_ready, h_valid, h_ready;
    t_rad    f_rad;
    t_half   h_half;

    t_coord              row_y, fs, fe, ss, se;
    logic [1:0]          count;
    logic [COLOR_W-1:0]  color;

    // Camera offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAMERA_X: r_cam_x <= i_cfg_data;
                REG_CAMERA_Y: r_cam_y <= i_cfg_data;
                default:      r_cam_x <= r_cam_x;
            endcase
        end
    end

    crrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cam_x      (r_cam_x),
        .i_cam_y      (r_cam_y),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_center_x   (s_axis_tdata[19:0]),
        .i_center_y   (s_axis_tdata[39:20]),
        .i_radius     (s_axis_tdata[50:40]),
        .i_thickness  (s_axis_tdata[61:51]),
        .i_row_offset (s_axis_tdata[73:62]),
        .i_color      (s_axis_tdata[105:74]),
        .o_valid      (f_valid),
        .i_ready      (f_ready),
        .o_rad        (f_rad)
    );

    crrs_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_rad   (f_rad),
        .o_valid (h_valid),
        .i_ready (h_ready),
        .o_half  (h_half)
    );

    crrs_spans u_spans (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (h_valid),
        .o_ready        (h_ready),
        .i_half         (h_half),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_row_y        (row_y),
        .o_span_count   (count),
        .o_first_start  (fs),
        .o_first_end    (fe),
        .o_second_start (ss),
        .o_second_end   (se),
        .o_color_out    (color)
    );

    // Pack the result item
    assign m_axis_tdata = {2'b00, color, se, ss, fe, fs, count, row_y};

endmodule
